[rtl/pid_motor_controller_defines.svh]
// assertion macros for the pid motor controller
// used by the top level only, no other dependencies
`ifndef PID_MOTOR_CONTROLLER_DEFINES_SVH
`define PID_MOTOR_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pmc_pkg.sv]
// shared types and constants for the pid motor controller
// no dependencies
package pmc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTPUT     = 3'd6;

    localparam logic MODE_INCR = 1'b0;
    localparam logic MODE_POS  = 1'b1;

    localparam int CFG_DATA_W = 47;
    localparam int SUM_W      = 60;

    typedef struct packed {
        logic        mode;
        logic [23:0] gain_p;
        logic [23:0] gain_i;
        logic [23:0] gain_d;
        logic [30:0] dead_zone;
        logic [46:0] integral_limit;
        logic [30:0] max_output;
    } pmc_cfg_t;

    // one classified word between front and back
    typedef struct packed {
        logic               brake;
        logic               neg;
        logic signed [31:0] err;
        logic signed [32:0] derr;
        logic signed [47:0] integ;
    } pmc_work_t;

endpackage

[rtl/pmc_fifo.sv]
// small first-word-fall-through queue of flip-flops
// no dependencies
module pmc_fifo #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [Width-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [Width-1:0]             rd_data,
    output logic [$clog2(Depth+1)-1:0]   count,
    output logic                         not_empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign not_empty = (count_reg != '0);

endmodule

[rtl/pmc_front.sv]
// front end: error forming, dead zone, integral and derivative difference
// depends on pmc_pkg
module pmc_front
    import pmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pmc_cfg_t           cfg,
    input  logic               in_valid,
    input  logic signed [31:0] target,
    input  logic signed [31:0] feedback,
    output logic               work_valid,
    output pmc_work_t          work
);

    logic               f1_valid_reg;
    logic signed [31:0] f1_err_reg;
    logic               f1_brake_reg;
    logic               f1_neg_reg;
    logic signed [47:0] integ_reg, integ_next;
    logic signed [31:0] prev_err_reg;

    logic signed [32:0] diff;
    logic signed [31:0] err_sat;
    logic signed [32:0] err_ext;
    logic signed [32:0] dz_s;
    logic               in_dz;
    logic signed [31:0] err_next;

    logic signed [48:0] isum;
    logic signed [48:0] lim_s;
    logic signed [48:0] lim_neg;
    logic signed [48:0] iclamp;
    logic signed [32:0] derr;

    // stage one: saturated error with dead zone
    always_comb
    begin
        diff = {target[31], target} - {feedback[31], feedback};
        if (diff[32] != diff[31])
        begin
            err_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            err_sat = diff[31:0];
        end
        err_ext  = {err_sat[31], err_sat};
        dz_s     = $signed({2'b00, cfg.dead_zone});
        in_dz    = (err_ext < dz_s) && (err_ext > -dz_s);
        err_next = in_dz ? '0 : err_sat;
    end

    // stage two: clamped integral, cleared on brake
    always_comb
    begin
        isum    = {integ_reg[47], integ_reg} + {{17{f1_err_reg[31]}}, f1_err_reg};
        lim_s   = $signed({2'b00, cfg.integral_limit});
        lim_neg = -lim_s;
        if (isum > lim_s)
        begin
            iclamp = lim_s;
        end
        else if (isum < lim_neg)
        begin
            iclamp = lim_neg;
        end
        else
        begin
            iclamp = isum;
        end
        integ_next = f1_brake_reg ? '0 : iclamp[47:0];
        derr       = {f1_err_reg[31], f1_err_reg} - {prev_err_reg[31], prev_err_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            f1_valid_reg <= in_valid;
            if (f1_valid_reg)
            begin
                integ_reg    <= integ_next;
                prev_err_reg <= f1_err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            f1_err_reg   <= err_next;
            f1_brake_reg <= (cfg.mode == MODE_INCR) && (target == '0);
            f1_neg_reg   <= target[31];
        end
    end

    assign work_valid  = f1_valid_reg;
    assign work.brake  = f1_brake_reg;
    assign work.neg    = f1_neg_reg;
    assign work.err    = f1_err_reg;
    assign work.derr   = derr;
    assign work.integ  = integ_next;

endmodule

[rtl/pmc_back.sv]
// back end: gain multiplies, term sum and output clamp with held output
// depends on pmc_pkg
module pmc_back
    import pmc_pkg::*;
#(
    parameter int OutDepth = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmc_cfg_t                      cfg,
    input  logic                          q_valid,
    input  pmc_work_t                     q_item,
    output logic                          q_pop,
    input  logic [$clog2(OutDepth+1)-1:0] out_count,
    output logic                          res_valid,
    output logic signed [31:0]            res_drive
);

    localparam int CntW = $clog2(OutDepth + 1);

    logic [1:0]          inflight;
    logic [CntW+1:0]     pending;

    logic                b1_valid_reg, b2_valid_reg, b3_valid_reg;
    logic signed [56:0]  b1_pp_reg;
    logic signed [57:0]  b1_pd_reg;
    logic [47:0]         b1_pil_reg;
    logic signed [48:0]  b1_pih_reg;
    logic                b1_brake_reg, b1_neg_reg;
    logic signed [SUM_W-1:0] b2_ti_reg, b2_tpd_reg;
    logic                b2_brake_reg, b2_neg_reg;
    logic signed [SUM_W-1:0] b3_sum_reg;
    logic                b3_brake_reg, b3_neg_reg;
    logic signed [31:0]  held_reg, held_next;

    logic signed [56:0]  pp_next;
    logic signed [57:0]  pd_next;
    logic [47:0]         pil_next;
    logic signed [48:0]  pih_next;
    logic signed [72:0]  ti_full;
    logic signed [SUM_W-1:0] ti_next, tpd_next;
    logic signed [SUM_W-1:0] acc, mx, lo, hi, clamped;

    // take a word only when the result queue has room for all in flight
    always_comb
    begin
        inflight = 2'(b1_valid_reg) + 2'(b2_valid_reg) + 2'(b3_valid_reg);
        pending  = (CntW+2)'(out_count) + (CntW+2)'(inflight);
        q_pop    = q_valid && (pending < (CntW+2)'(OutDepth));
    end

    always_comb
    begin
        pp_next  = $signed({1'b0, cfg.gain_p}) * q_item.err;
        pd_next  = $signed({1'b0, cfg.gain_d}) * q_item.derr;
        pil_next = cfg.gain_i * q_item.integ[23:0];
        pih_next = $signed({1'b0, cfg.gain_i}) * $signed(q_item.integ[47:24]);
    end

    // floor shifts by sixteen are the top bits of each product
    always_comb
    begin
        ti_full  = $signed({b1_pih_reg, 24'b0}) + $signed({25'b0, b1_pil_reg});
        ti_next  = {{3{ti_full[72]}}, ti_full[72:16]};
        tpd_next = {{19{b1_pp_reg[56]}}, b1_pp_reg[56:16]}
                 + {{18{b1_pd_reg[57]}}, b1_pd_reg[57:16]};
    end

    always_comb
    begin
        mx = $signed({{(SUM_W-31){1'b0}}, cfg.max_output});
        if (cfg.mode == MODE_INCR)
        begin
            acc = {{(SUM_W-32){held_reg[31]}}, held_reg} + b3_sum_reg;
            lo  = b3_neg_reg ? -mx : '0;
            hi  = b3_neg_reg ? '0 : mx;
        end
        else
        begin
            acc = b3_sum_reg;
            lo  = -mx;
            hi  = mx;
        end
        if (acc < lo)
        begin
            clamped = lo;
        end
        else if (acc > hi)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = acc;
        end
        held_next = b3_brake_reg ? '0 : clamped[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            held_reg     <= '0;
        end
        else
        begin
            b1_valid_reg <= q_pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            if (b3_valid_reg)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_pp_reg    <= pp_next;
            b1_pd_reg    <= pd_next;
            b1_pil_reg   <= pil_next;
            b1_pih_reg   <= pih_next;
            b1_brake_reg <= q_item.brake;
            b1_neg_reg   <= q_item.neg;
        end
        if (b1_valid_reg)
        begin
            b2_ti_reg    <= ti_next;
            b2_tpd_reg   <= tpd_next;
            b2_brake_reg <= b1_brake_reg;
            b2_neg_reg   <= b1_neg_reg;
        end
        if (b2_valid_reg)
        begin
            b3_sum_reg   <= b2_ti_reg + b2_tpd_reg;
            b3_brake_reg <= b2_brake_reg;
            b3_neg_reg   <= b2_neg_reg;
        end
    end

    assign res_valid = b3_valid_reg;
    assign res_drive = held_next;

endmodule

[rtl/pid_motor_controller.sv]
// top level of the pid motor controller: config registers, front, queues, back
// depends on pmc_pkg, pmc_fifo, pmc_front, pmc_back, pid_motor_controller_defines.svh
//
//  channel   handshake          word
//  -------   ----------------   ---------------------------------------
//  input     push / full        target, feedback (signed q16.16)
//  result    pop / empty        drive (signed q16.16)
//  config    cfg_write          cfg_index selects, cfg_data carries value
//
// one word per cycle sustained while the consumer keeps popping; a pushed word
// reaches the result queue through one front stage, work queue, three back stages
// the integral add-and-clamp and the held-output add-and-clamp each loop back
// through a single register, so consecutive words need no spacing
// reset clears config to defaults, state to zero and both queues to empty
// full rises when the work queue has no room beyond the word still in the front;
// the back holds words in the work queue while the result queue lacks room
module pid_motor_controller
    import pmc_pkg::*;
#(
    parameter int QueueDepth = 4,
    parameter int OutDepth   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic signed [31:0]    target,
    input  logic signed [31:0]    feedback,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [31:0]    drive,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QCntW = $clog2(QueueDepth + 1);
    localparam int OCntW = $clog2(OutDepth + 1);

    pmc_cfg_t cfg_reg, cfg_next;

    logic             in_take;
    logic             work_valid;
    pmc_work_t        work;
    logic [QCntW-1:0] q_count;
    logic             q_not_empty;
    pmc_work_t        q_item;
    logic             q_pop;

    logic             res_valid;
    logic signed [31:0] res_drive;
    logic [OCntW-1:0] o_count;
    logic             o_not_empty;
    logic             o_pop;

    logic             drive_in_lim;

    // register file, writes land unconditionally; unused index ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:           cfg_next.mode           = cfg_data[0];
                CFG_GAIN_P:         cfg_next.gain_p         = cfg_data[23:0];
                CFG_GAIN_I:         cfg_next.gain_i         = cfg_data[23:0];
                CFG_GAIN_D:         cfg_next.gain_d         = cfg_data[23:0];
                CFG_DEAD_ZONE:      cfg_next.dead_zone      = cfg_data[30:0];
                CFG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[46:0];
                CFG_MAX_OUTPUT:     cfg_next.max_output     = cfg_data[30:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_INCR;
            cfg_reg.gain_p         <= 24'd2741371;
            cfg_reg.gain_i         <= 24'd0;
            cfg_reg.gain_d         <= 24'd2103050;
            cfg_reg.dead_zone      <= 31'd3277;
            cfg_reg.integral_limit <= 47'h7FFF_FFFF_FFFF;
            cfg_reg.max_output     <= 31'd1048576000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // credit check: queued words plus the one in the front stage
    assign full    = ((QCntW+1)'(q_count) + (QCntW+1)'(work_valid))
                     >= (QCntW+1)'(QueueDepth);
    assign in_take = push && !full;

    pmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_take),
        .target     (target),
        .feedback   (feedback),
        .work_valid (work_valid),
        .work       (work)
    );

    // work queue between front and back
    pmc_fifo #(
        .Width ($bits(pmc_work_t)),
        .Depth (QueueDepth)
    ) u_work_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (work_valid),
        .wr_data   (work),
        .rd_en     (q_pop),
        .rd_data   (q_item),
        .count     (q_count),
        .not_empty (q_not_empty)
    );

    pmc_back #(
        .OutDepth (OutDepth)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_count (o_count),
        .res_valid (res_valid),
        .res_drive (res_drive)
    );

    // result queue, parts the back from the consumer
    assign o_pop = pop && o_not_empty;

    pmc_fifo #(
        .Width (32),
        .Depth (OutDepth)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (res_valid),
        .wr_data   (res_drive),
        .rd_en     (o_pop),
        .rd_data   (drive),
        .count     (o_count),
        .not_empty (o_not_empty)
    );

    assign empty = !o_not_empty;

    // head word magnitude against the output limit, both sign-extended
    assign drive_in_lim = ($signed({drive[31], drive}) <= $signed({2'b00, cfg_reg.max_output}))
                       && ($signed({drive[31], drive}) >= -$signed({2'b00, cfg_reg.max_output}));

    `include "pid_motor_controller_defines.svh"

    // the front never writes into a full work queue
    `PMC_ASSERT_NOW(a_work_q_room, clk, rst_n, work_valid, q_count < QCntW'(QueueDepth), "work queue overrun")

    // the back never writes into a full result queue
    `PMC_ASSERT_NOW(a_res_q_room, clk, rst_n, res_valid, o_count < OCntW'(OutDepth), "result queue overrun")

    // the result at the head, when one waits, lies within the output limit
    `PMC_ASSERT_NOW(a_drive_limit, clk, rst_n, !empty, drive_in_lim, "drive beyond limit")

    // taking the last result with nothing arriving leaves the queue empty
    `PMC_ASSERT_NEXT(a_drain, clk, rst_n, o_pop && (o_count == OCntW'(1)) && !res_valid, empty, "result queue failed to drain")

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for pid_motor_controller: directed table then random phases
// depends on pmc_pkg and the pid_motor_controller rtl; the drive predictor is local
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pmc_pkg::*;

    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    localparam int PLAN_LEN   = 39;
    localparam int WORDS_RAND = 50;   // words per random phase
    localparam int PHASES     = 10;
    localparam int SETTLE     = 12;   // idle wait after the last expected drive word comes out

    // directed table rows: a word to push, or a register write between words
    typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [46:0]        arg_a;      // target, or register index
        logic [46:0]        arg_b;      // feedback, or register data
        logic               checked;    // drive typed in below
        logic signed [31:0] drive_val;
    } plan_row_t;

    // typed drive values are only the obvious ones: brake, saturation, zero gains
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // reset config, incremental: zero target always brakes
        '{ROW_WORD, 0, 0, 1'b1, 0},
        '{ROW_WORD, 0, 32'h7FFF_FFFF, 1'b1, 0},
        '{ROW_WORD, 0, 32'h8000_0000, 1'b1, 0},
        // either side of the dead zone edge
        '{ROW_WORD, 3276, 0, 1'b0, 0},
        '{ROW_WORD, 3277, 0, 1'b0, 0},
        '{ROW_WORD, -3277, 0, 1'b0, 0},
        // saturated error, clamped by the sign of the target
        '{ROW_WORD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1048576000},
        '{ROW_WORD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, -1048576000},
        '{ROW_WORD, 100000, 200000, 1'b0, 0},
        // positional, zero integral limit, widest output range
        '{ROW_REG, CFG_MODE, MODE_POS, 1'b0, 0},
        '{ROW_REG, CFG_GAIN_I, 24'hFF_FFFF, 1'b0, 0},
        '{ROW_REG, CFG_INTEGRAL_LIMIT, 0, 1'b0, 0},
        '{ROW_REG, CFG_DEAD_ZONE, 0, 1'b0, 0},
        '{ROW_REG, CFG_MAX_OUTPUT, 31'h7FFF_FFFF, 1'b0, 0},
        '{ROW_WORD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'sh7FFF_FFFF},
        // no brake in positional mode, the derivative swings it to the floor
        '{ROW_WORD, 0, 0, 1'b1, -32'sd2147483647},
        '{ROW_REG, CFG_INTEGRAL_LIMIT, 47'h7FFF_FFFF_FFFF, 1'b0, 0},
        '{ROW_WORD, 1, 0, 1'b0, 0},
        '{ROW_WORD, -1, 0, 1'b0, 0},
        '{ROW_WORD, 32'h7FFF_FFFF, 0, 1'b0, 0},
        '{ROW_WORD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0},
        // all gains zero
        '{ROW_REG, CFG_GAIN_P, 0, 1'b0, 0},
        '{ROW_REG, CFG_GAIN_I, 0, 1'b0, 0},
        '{ROW_REG, CFG_GAIN_D, 0, 1'b0, 0},
        '{ROW_WORD, 32'h1234_5678, 0, 1'b1, 0},
        // largest gains against a zero output limit
        '{ROW_REG, CFG_GAIN_P, 24'hFF_FFFF, 1'b0, 0},
        '{ROW_REG, CFG_GAIN_D, 24'hFF_FFFF, 1'b0, 0},
        '{ROW_REG, CFG_MAX_OUTPUT, 0, 1'b0, 0},
        '{ROW_WORD, 32'h4000_0000, 0, 1'b1, 0},
        // back to incremental, held output carries over, widest dead zone
        '{ROW_REG, CFG_MODE, MODE_INCR, 1'b0, 0},
        '{ROW_REG, CFG_MAX_OUTPUT, 1048576000, 1'b0, 0},
        '{ROW_REG, CFG_DEAD_ZONE, 31'h7FFF_FFFF, 1'b0, 0},
        '{ROW_WORD, 32'h0001_0000, 0, 1'b0, 0},
        '{ROW_WORD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0},
        '{ROW_WORD, -32'h0001_0000, 0, 1'b0, 0},
        // write to the unmapped index changes nothing
        '{ROW_REG, CFG_UNMAPPED, 47'h5555_5555_5555, 1'b0, 0},
        '{ROW_REG, CFG_DEAD_ZONE, 3277, 1'b0, 0},
        '{ROW_WORD, 32'h0001_0000, 32'h0000_8000, 1'b0, 0},
        '{ROW_WORD, 0, 32'h0000_1234, 1'b1, 0}
    };

    // corner values for the random part
    localparam logic signed [31:0] CORNER [5] = '{
        32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    logic signed [31:0]    target    = '0;
    logic signed [31:0]    feedback  = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic signed [31:0]    drive;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of the registers and the loop state
    pmc_cfg_t           ctl;
    logic signed [47:0] integ_acc;
    logic signed [31:0] last_err;
    logic signed [31:0] last_drive;

    logic signed [31:0] drive_expected [$];
    logic signed [31:0] want_drive;
    int                 fail_count = 0;

    pid_motor_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .target    (target),
        .feedback  (feedback),
        .empty     (empty),
        .pop       (pop),
        .drive     (drive),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // floor(gain * v / 2^16), exact at 80 bits
    function automatic logic signed [79:0] gain_term(input logic [23:0] g,
                                                     input logic signed [47:0] v);
        logic signed [79:0] gs;
        logic signed [79:0] vs;
        gs = $signed({56'b0, g});
        vs = v;
        return (gs * vs) >>> 16;
    endfunction

    // one control step: updates integral, last error and held drive
    function automatic logic signed [31:0] predict_drive(input logic signed [31:0] t,
                                                         input logic signed [31:0] f);
        logic signed [32:0] diff;
        logic signed [31:0] err;
        logic signed [32:0] dz;
        logic signed [48:0] acc;
        logic signed [48:0] lim;
        logic signed [32:0] derr;
        logic signed [79:0] sum;
        logic signed [79:0] total;
        logic signed [79:0] mx;
        logic signed [79:0] lo;
        logic signed [79:0] hi;
        logic               incr;
        incr = (ctl.mode == MODE_INCR);

        // error saturated to 32 bits, then the dead zone
        diff = t - f;
        if (diff > 33'sh0_7FFF_FFFF)
            err = 32'sh7FFF_FFFF;
        else if (diff < -(33'sh0_8000_0000))
            err = 32'sh8000_0000;
        else
            err = diff[31:0];
        dz = $signed({2'b0, ctl.dead_zone});
        if (err < dz && err > -dz)
            err = '0;

        // integral clamped even with zero gain, brake clears it
        lim = $signed({2'b0, ctl.integral_limit});
        acc = integ_acc + err;
        if (acc > lim)
            acc = lim;
        else if (acc < -lim)
            acc = -lim;
        integ_acc = acc[47:0];
        if (incr && t == 0)
            integ_acc = '0;

        derr = err - last_err;
        sum = gain_term(ctl.gain_p, err) + gain_term(ctl.gain_i, integ_acc)
            + gain_term(ctl.gain_d, derr);

        mx = $signed({49'b0, ctl.max_output});
        if (incr)
        begin
            total = last_drive + sum;
            if (t >= 0)
            begin
                lo = '0;
                hi = mx;
            end
            else
            begin
                lo = -mx;
                hi = '0;
            end
            if (t == 0)
                total = '0;
        end
        else
        begin
            total = sum;
            lo = -mx;
            hi = mx;
        end
        if (total < lo)
            total = lo;
        else if (total > hi)
            total = hi;

        last_err = err;
        last_drive = total[31:0];
        return last_drive;
    endfunction

    // register values: all zeros, all ones, or random at a random magnitude
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return raw[CFG_DATA_W-1:0] >> $urandom_range(0, CFG_DATA_W - 1);
        endcase
    endfunction

    // a word is taken at a rising edge with push high and full low;
    // called and returning at a falling edge, push left high for the next word
    task automatic send_word(input logic signed [31:0] t, input logic signed [31:0] f,
                             input logic checked, input logic signed [31:0] typed_drive,
                             input logic calm);
        int                 gap;
        logic signed [31:0] modelled;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        target <= t;
        feedback <= f;
        @(posedge clk);
        while (full)
            @(posedge clk);
        modelled = predict_drive(t, f);
        drive_expected.push_back(checked ? typed_drive : modelled);
        @(negedge clk);
    endtask

    // register write at a falling edge, predictor copy updated alongside
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_MODE:           ctl.mode = data[0];
            CFG_GAIN_P:         ctl.gain_p = data[23:0];
            CFG_GAIN_I:         ctl.gain_i = data[23:0];
            CFG_GAIN_D:         ctl.gain_d = data[23:0];
            CFG_DEAD_ZONE:      ctl.dead_zone = data[30:0];
            CFG_INTEGRAL_LIMIT: ctl.integral_limit = data[46:0];
            CFG_MAX_OUTPUT:     ctl.max_output = data[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // stop pushing and let every outstanding drive word come out
    task automatic wait_idle();
        push <= 1'b0;
        while (drive_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // random word shapes: near-equal pairs dominate so the loop stays out of saturation
    task automatic random_word(output logic signed [31:0] t, output logic signed [31:0] f);
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8:
            begin
                t = a;
                f = a - (b >>> $urandom_range(6, 31));
            end
            9, 10, 11, 12:
            begin
                t = a;
                f = b;
            end
            13, 14:
            begin
                t = '0;
                f = b >>> $urandom_range(0, 31);
            end
            15, 16:
            begin
                t = CORNER[$urandom_range(0, 4)];
                f = CORNER[$urandom_range(0, 4)];
            end
            default:
            begin
                t = a >>> $urandom_range(8, 24);
                f = b >>> $urandom_range(8, 24);
            end
        endcase
    endtask

    // result side: oldest drive word compared on every accepted pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (drive_expected.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("drive word %0d with nothing outstanding", drive);
            end
            else
            begin
                want_drive = drive_expected.pop_front();
                if (drive !== want_drive)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("drive mismatch: expected %0d, got %0d", want_drive, drive);
                end
            end
        end
    end

    // pop with random stalls, with the odd calm stretch of back-to-back pops
    initial
    begin
        int pop_wait;
        int pop_calm;
        pop_wait = 0;
        pop_calm = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pop_wait > 0)
            begin
                pop <= 1'b0;
                pop_wait--;
            end
            else
            begin
                pop <= 1'b1;
                pop_wait = (pop_calm > 0) ? 0 : pick_gap();
            end
            if (pop_calm > 0)
                pop_calm--;
            else if ($urandom_range(0, 39) == 0)
                pop_calm = $urandom_range(20, 80);
        end
    end

    // main sequence: reset, directed table, random phases, drain
    initial
    begin
        logic signed [31:0] t;
        logic signed [31:0] f;
        logic               calm;

        // predictor starts from the reset defaults
        ctl.mode = MODE_INCR;
        ctl.gain_p = 24'd2741371;
        ctl.gain_i = 24'd0;
        ctl.gain_d = 24'd2103050;
        ctl.dead_zone = 31'd3277;
        ctl.integral_limit = 47'h7FFF_FFFF_FFFF;
        ctl.max_output = 31'd1048576000;
        integ_acc = '0;
        last_err = '0;
        last_drive = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(PLAN[i].arg_a[CFG_IDX_W-1:0], PLAN[i].arg_b);
            end
            else
                send_word(PLAN[i].arg_a[31:0], PLAN[i].arg_b[31:0], PLAN[i].checked,
                          PLAN[i].drive_val, 1'b0);
        end

        // each phase: drain, alternate the mode, rewrite a random set of registers
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            write_reg(CFG_MODE, (phase % 2 == 0) ? MODE_INCR : MODE_POS);
            for (int r = CFG_GAIN_P; r <= CFG_MAX_OUTPUT; r++)
                if ($urandom_range(0, 1) == 1)
                    write_reg(r[CFG_IDX_W-1:0], pick_reg_value());
            calm = ($urandom_range(0, 3) == 0);
            repeat (WORDS_RAND)
            begin
                random_word(t, f);
                send_word(t, f, 1'b0, '0, calm);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS pid_motor_controller");
        else
            $display("FAIL pid_motor_controller");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL pid_motor_controller");
        $finish;
    end

endmodule
